// ----- rtl/core/tracker_pattern_unpacker_assert.svh -----
// Assertion shorthands, clocked on clk and held off while arst_n is low.
`ifndef TRACKER_PATTERN_UNPACKER_ASSERT_SVH
`define TRACKER_PATTERN_UNPACKER_ASSERT_SVH

// Same-cycle implication.
`define TPU_ASSERT_IMP(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define TPU_ASSERT_NXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- rtl/core/tpu_pkg.sv -----
package tpu_pkg;

	localparam int CNT_W = 9;
	localparam int MASK_W = 5;
	localparam int BYTE_W = 8;
	localparam int HELD_N = 4;
	localparam int CH_OUT_W = 5;
	localparam int ROW_OUT_W = 8;

	localparam logic [CNT_W-1:0] KEPT_CHANNELS = 9'd32;
	localparam logic [CNT_W-1:0] MAX_ROWS = 9'd256;
	localparam logic [CNT_W-1:0] FILE_CHANNELS_RST = 9'd32;
	localparam logic [CNT_W-1:0] PATTERN_ROWS_RST = 9'd64;

	// lead byte: bit 7 marks a packed mask
	localparam int LEAD_MASK_BIT = 7;
	// plain note lead: instrument, volume, effect, parameter follow
	localparam logic [MASK_W-1:0] FULL_MASK = 5'b11110;

	typedef enum logic [0:0] {
		REG_FILE_CHANNELS = 1'b0,
		REG_PATTERN_ROWS  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic              done;
		logic [BYTE_W-1:0] note;
		logic [BYTE_W-1:0] instrument;
		logic [BYTE_W-1:0] volume;
		logic [BYTE_W-1:0] effect;
		logic [BYTE_W-1:0] param;
	} slot_t;

	typedef struct packed {
		logic                 emit;
		logic                 with_fields;
		logic                 done;
		logic                 trunc;
		logic [CH_OUT_W-1:0]  channel;
		logic [ROW_OUT_W-1:0] row;
	} pos_t;

endpackage

// ----- rtl/core/tpu_slot_parser.sv -----
module tpu_slot_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [tpu_pkg::BYTE_W-1:0] data,
	output tpu_pkg::slot_t         slot
);
	import tpu_pkg::*;

	logic [MASK_W-1:0]             mask_q;
	logic [MASK_W-1:0]             mask_n;
	logic [HELD_N-1:0][BYTE_W-1:0] held_q;
	logic [HELD_N-1:0][BYTE_W-1:0] held_n;
	logic [BYTE_W-1:0]             param;

	always_comb begin
		mask_n = mask_q;
		held_n = held_q;
		param  = '0;
		if (mask_q == '0) begin
			held_n = '0;
			if (data[LEAD_MASK_BIT]) begin
				mask_n = data[MASK_W-1:0];
			end else begin
				held_n[0] = data;
				mask_n    = FULL_MASK;
			end
		end else begin
			priority if (mask_q[0]) begin
				held_n[0] = data;
				mask_n[0] = 1'b0;
			end else if (mask_q[1]) begin
				held_n[1] = data;
				mask_n[1] = 1'b0;
			end else if (mask_q[2]) begin
				held_n[2] = data;
				mask_n[2] = 1'b0;
			end else if (mask_q[3]) begin
				held_n[3] = data;
				mask_n[3] = 1'b0;
			end else begin
				param     = data;
				mask_n[4] = 1'b0;
			end
		end
	end

	assign slot.done       = (mask_n == '0);
	assign slot.note       = held_n[0];
	assign slot.instrument = held_n[1];
	assign slot.volume     = held_n[2];
	assign slot.effect     = held_n[3];
	assign slot.param      = param;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (step) begin
			mask_q <= mask_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			held_q <= held_n;
		end
	end

endmodule

// ----- rtl/core/tpu_position.sv -----
module tpu_position (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic                      slot_done,
	input  logic                      eod,
	input  logic [tpu_pkg::CNT_W-1:0] file_channels,
	input  logic [tpu_pkg::CNT_W-1:0] pattern_rows,
	output tpu_pkg::pos_t             pos,
	output logic                      complete
);
	import tpu_pkg::*;

	logic [CNT_W-1:0] chan_q;
	logic [CNT_W-1:0] row_q;
	logic             complete_q;
	logic [CNT_W-1:0] ch_inc;
	logic [CNT_W-1:0] row_inc;
	logic [CNT_W-1:0] rows_lim;
	logic             wrap;
	logic             end_rows;
	logic             kept;
	logic             comp_n;

	assign ch_inc   = chan_q + 1'b1;
	assign row_inc  = row_q + 1'b1;
	assign rows_lim = (pattern_rows > MAX_ROWS) ? MAX_ROWS : pattern_rows;
	assign wrap     = (ch_inc >= file_channels);
	assign end_rows = wrap && (row_inc >= rows_lim);
	assign kept     = (chan_q < KEPT_CHANNELS);

	always_comb begin
		if (slot_done) begin
			comp_n          = end_rows || eod;
			pos.trunc       = eod && !end_rows;
			pos.with_fields = kept;
			pos.emit        = kept || comp_n;
		end else begin
			comp_n          = eod;
			pos.trunc       = 1'b1;
			pos.with_fields = 1'b0;
			pos.emit        = eod;
		end
		pos.done    = comp_n;
		pos.channel = chan_q[CH_OUT_W-1:0];
		pos.row     = row_q[ROW_OUT_W-1:0];
	end

	assign complete = complete_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q     <= '0;
			row_q      <= '0;
			complete_q <= 1'b0;
		end else if (step) begin
			if (slot_done) begin
				chan_q <= wrap ? '0 : ch_inc;
				row_q  <= wrap ? row_inc : row_q;
			end
			complete_q <= comp_n;
		end
	end

endmodule

// ----- rtl/core/tracker_pattern_unpacker.sv -----
// Packed tracker pattern unpacker. Takes one byte of packed pattern data per
// cycle on the data channel while data_stall is low and gives at most one note
// record per byte on the record channel; each byte passes through the input
// register and then the record register. The byte-by-byte slot parse and the
// channel/row counters are resolved combinationally, which sets the rate of one
// byte per clock. Once the pattern ends (all rows done, or end_of_data seen),
// further bytes are taken and dropped until reset. file_channels and
// pattern_rows may only be written while no request is in flight.
module tracker_pattern_unpacker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [tpu_pkg::CNT_W-1:0]     cfg_data,
	input  logic                          data_valid,
	output logic                          data_stall,
	input  logic [tpu_pkg::BYTE_W-1:0]    data_byte,
	input  logic                          end_of_data,
	output logic                          rec_valid,
	input  logic                          rec_stall,
	output logic [tpu_pkg::CH_OUT_W-1:0]  channel,
	output logic [tpu_pkg::ROW_OUT_W-1:0] row,
	output logic [tpu_pkg::BYTE_W-1:0]    note,
	output logic [tpu_pkg::BYTE_W-1:0]    instrument,
	output logic [tpu_pkg::BYTE_W-1:0]    volume,
	output logic [tpu_pkg::BYTE_W-1:0]    effect,
	output logic [tpu_pkg::BYTE_W-1:0]    effect_param,
	output logic                          pattern_done,
	output logic                          truncated
);
	import tpu_pkg::*;

	logic [CNT_W-1:0]  file_channels_q;
	logic [CNT_W-1:0]  pattern_rows_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              eod_s1;
	logic              rec_valid_q;
	logic              consume;
	logic              step;
	logic              load;
	logic              complete;
	slot_t             slot;
	pos_t              pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_channels_q <= FILE_CHANNELS_RST;
			pattern_rows_q  <= PATTERN_ROWS_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FILE_CHANNELS: file_channels_q <= cfg_data;
				REG_PATTERN_ROWS:  pattern_rows_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// request in s1 retires unless it would land on a held record
	assign consume    = valid_s1 && (!rec_valid_q || !rec_stall || complete || !pos.emit);
	assign step       = consume && !complete;
	assign load       = step && pos.emit;
	assign data_stall = valid_s1 && !consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && !data_stall) begin
			byte_s1 <= data_byte;
			eod_s1  <= end_of_data;
		end
	end

	tpu_slot_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.data   (byte_s1),
		.slot   (slot)
	);

	tpu_position u_position (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.slot_done     (slot.done),
		.eod           (eod_s1),
		.file_channels (file_channels_q),
		.pattern_rows  (pattern_rows_q),
		.pos           (pos),
		.complete      (complete)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (load) begin
			rec_valid_q <= 1'b1;
		end else if (!rec_stall) begin
			rec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			channel      <= pos.with_fields ? pos.channel : '0;
			row          <= pos.with_fields ? pos.row : '0;
			note         <= pos.with_fields ? slot.note : '0;
			instrument   <= pos.with_fields ? slot.instrument : '0;
			volume       <= pos.with_fields ? slot.volume : '0;
			effect       <= pos.with_fields ? slot.effect : '0;
			effect_param <= pos.with_fields ? slot.param : '0;
			pattern_done <= pos.done;
			truncated    <= pos.trunc;
		end
	end

	assign rec_valid = rec_valid_q;

`include "tracker_pattern_unpacker_assert.svh"

	`TPU_ASSERT_IMP(a_trunc_done, rec_valid_q && truncated, pattern_done, "truncated without done")
	`TPU_ASSERT_IMP(a_done_complete, rec_valid_q && pattern_done, complete, "done but not complete")
	`TPU_ASSERT_NXT(a_complete_sticky, complete, complete, "pattern end lost")
	`TPU_ASSERT_IMP(a_no_overwrite, load && rec_valid_q, !rec_stall, "held record overwritten")

endmodule

// ----- dv/tracker_pattern_unpacker_check.sv -----
`timescale 1ns / 100ps

module tracker_pattern_unpacker_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [tpu_pkg::CNT_W-1:0]     cfg_data,
	input  logic                          data_valid,
	input  logic                          data_stall,
	input  logic [tpu_pkg::BYTE_W-1:0]    data_byte,
	input  logic                          end_of_data,
	input  logic                          rec_valid,
	input  logic                          rec_stall,
	input  logic [tpu_pkg::CH_OUT_W-1:0]  channel,
	input  logic [tpu_pkg::ROW_OUT_W-1:0] row,
	input  logic [tpu_pkg::BYTE_W-1:0]    note,
	input  logic [tpu_pkg::BYTE_W-1:0]    instrument,
	input  logic [tpu_pkg::BYTE_W-1:0]    volume,
	input  logic [tpu_pkg::BYTE_W-1:0]    effect,
	input  logic [tpu_pkg::BYTE_W-1:0]    effect_param,
	input  logic                          pattern_done,
	input  logic                          truncated,
	output int                            mismatches,
	output int                            records_left,
	output int                            records_seen,
	output logic [tpu_pkg::CNT_W-1:0]     slot_channel,
	output logic [tpu_pkg::CNT_W-1:0]     slot_row
);
	import tpu_pkg::*;

	typedef struct packed {
		logic [CH_OUT_W-1:0]  channel;
		logic [ROW_OUT_W-1:0] row;
		logic [BYTE_W-1:0]    note;
		logic [BYTE_W-1:0]    instrument;
		logic [BYTE_W-1:0]    volume;
		logic [BYTE_W-1:0]    effect;
		logic [BYTE_W-1:0]    param;
		logic                 done;
		logic                 trunc;
	} note_rec_t;

	note_rec_t records_due[$];

	logic [CNT_W-1:0]  file_channels_r = FILE_CHANNELS_RST;
	logic [CNT_W-1:0]  pattern_rows_r = PATTERN_ROWS_RST;
	logic [CNT_W-1:0]  chan_cnt = '0;
	logic [CNT_W-1:0]  row_cnt = '0;
	logic [2:0]        field_idx = '0;
	logic [MASK_W-1:0] pending = '0;
	logic [BYTE_W-1:0] held [HELD_N] = '{default: '0};
	logic              ended = 1'b0;

	int fail_cnt = 0;
	int due_cnt = 0;
	int seen_cnt = 0;

	assign mismatches = fail_cnt;
	assign records_left = due_cnt;
	assign records_seen = seen_cnt;
	assign slot_channel = chan_cnt;
	assign slot_row = row_cnt;

	function automatic int low_bit(input logic [MASK_W-1:0] m);
		for (int k = 0; k < MASK_W; k++)
			if (m[k])
				return k;
		return 0;
	endfunction

	task automatic report(input string msg);
		$display("MISMATCH record %0d at %0t: %s", seen_cnt, $realtime, msg);
		fail_cnt++;
	endtask

	task automatic cmp_field(input string name, input int got, input int want);
		if (got != want)
			report($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	// one packed byte in, zero or one note record out
	task automatic unpack_byte(input logic [BYTE_W-1:0] b, input logic eod);
		logic [BYTE_W-1:0] fx;
		logic [CNT_W-1:0]  ch_at;
		logic [CNT_W-1:0]  rw_at;
		logic [CNT_W-1:0]  row_lim;
		logic              cut;
		int                k;
		note_rec_t         rec;
		if (ended)
			return;
		fx = '0;
		rec = '0;
		if (field_idx == 0 || pending == 0) begin
			foreach (held[i])
				held[i] = '0;
			if (b[LEAD_MASK_BIT]) begin
				pending = b[MASK_W-1:0];
			end else begin
				held[0] = b;
				pending = FULL_MASK;
			end
		end else begin
			k = low_bit(pending);
			if (k < HELD_N)
				held[k] = b;
			else
				fx = b;
			pending[k] = 1'b0;
		end
		if (pending != 0) begin
			field_idx = 3'(1 + low_bit(pending));
			// data ran out inside a slot: drop it, close the pattern
			if (eod) begin
				ended = 1'b1;
				rec.done = 1'b1;
				rec.trunc = 1'b1;
				records_due.push_back(rec);
			end
			return;
		end
		field_idx = '0;
		ch_at = chan_cnt;
		rw_at = row_cnt;
		row_lim = (pattern_rows_r > MAX_ROWS) ? MAX_ROWS : pattern_rows_r;
		chan_cnt = chan_cnt + 1'b1;
		if (chan_cnt >= file_channels_r) begin
			chan_cnt = '0;
			row_cnt = row_cnt + 1'b1;
			if (row_cnt >= row_lim)
				ended = 1'b1;
		end
		cut = eod && !ended;
		if (eod)
			ended = 1'b1;
		if (ch_at < KEPT_CHANNELS)
			rec = '{ch_at[CH_OUT_W-1:0], rw_at[ROW_OUT_W-1:0], held[0], held[1], held[2],
				held[3], fx, 1'b0, 1'b0};
		else if (!ended)
			return;
		rec.done = ended;
		rec.trunc = cut;
		records_due.push_back(rec);
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		note_rec_t want;
		if (!arst_n) begin
			file_channels_r = FILE_CHANNELS_RST;
			pattern_rows_r = PATTERN_ROWS_RST;
			chan_cnt = '0;
			row_cnt = '0;
			field_idx = '0;
			pending = '0;
			foreach (held[i])
				held[i] = '0;
			ended = 1'b0;
			records_due.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_FILE_CHANNELS)
					file_channels_r = cfg_data;
				else
					pattern_rows_r = cfg_data;
			end
			if (data_valid && !data_stall)
				unpack_byte(data_byte, end_of_data);
			if (rec_valid && !rec_stall) begin
				if (records_due.size() == 0) begin
					report("record arrived with none expected");
				end else begin
					want = records_due.pop_front();
					cmp_field("channel", int'(channel), int'(want.channel));
					cmp_field("row", int'(row), int'(want.row));
					cmp_field("note", int'(note), int'(want.note));
					cmp_field("instrument", int'(instrument), int'(want.instrument));
					cmp_field("volume", int'(volume), int'(want.volume));
					cmp_field("effect", int'(effect), int'(want.effect));
					cmp_field("effect_param", int'(effect_param), int'(want.param));
					cmp_field("pattern_done", int'(pattern_done), int'(want.done));
					cmp_field("truncated", int'(truncated), int'(want.trunc));
				end
				seen_cnt++;
			end
		end
		due_cnt = records_due.size();
	end

endmodule

// ----- dv/tracker_pattern_unpacker_test.sv -----
`timescale 1ns / 100ps

module tracker_pattern_unpacker_test;
	import tpu_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD = 60;
	localparam int RANDOM_BYTES = 400;

	typedef enum int {
		END_ROWS_KEPT,
		END_ROWS_DROPPED,
		END_EOD_KEPT,
		END_EOD_DROPPED,
		END_EOD_PARTIAL,
		END_ROWS_WITH_EOD
	} ending_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [0:0]           cfg_index = REG_FILE_CHANNELS;
	logic [CNT_W-1:0]     cfg_data = '0;
	logic                 data_valid = 1'b0;
	logic                 data_stall;
	logic [BYTE_W-1:0]    data_byte = '0;
	logic                 end_of_data = 1'b0;
	logic                 rec_valid;
	logic                 rec_stall = 1'b0;
	logic [CH_OUT_W-1:0]  channel;
	logic [ROW_OUT_W-1:0] row;
	logic [BYTE_W-1:0]    note;
	logic [BYTE_W-1:0]    instrument;
	logic [BYTE_W-1:0]    volume;
	logic [BYTE_W-1:0]    effect;
	logic [BYTE_W-1:0]    effect_param;
	logic                 pattern_done;
	logic                 truncated;

	int               mismatches;
	int               records_left;
	int               records_seen;
	logic [CNT_W-1:0] slot_channel;
	logic [CNT_W-1:0] slot_row;

	bit jitter_on = 1'b1;
	bit long_hold = 1'b0;
	int bytes_sent = 0;
	int reg_writes = 0;
	int cycles = 0;

	always #5 clk = ~clk;

	tracker_pattern_unpacker dut (.*);

	tracker_pattern_unpacker_check unpack_check (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tracker_pattern_unpacker verification failed");
			$finish;
		end
	end

	// record side: short random holds, one long hold on request
	initial begin : rx_side
		forever begin
			@(negedge clk);
			if (long_hold) begin
				rec_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				rec_stall <= 1'b0;
				long_hold = 1'b0;
			end else if (jitter_on && $urandom_range(0, 4) == 0) begin
				rec_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				rec_stall <= 1'b0;
			end
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
		if (jitter_on && $urandom_range(0, 3) == 0) begin
			data_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		end_of_data <= last;
		@(posedge clk);
		while (data_stall)
			@(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	// cut >= 0 sends at most that many of the following bytes
	task automatic send_slot(input logic [BYTE_W-1:0] lead, input logic eod, input int cut);
		int follow;
		follow = lead[LEAD_MASK_BIT] ? $countones(lead[MASK_W-1:0]) : $countones(FULL_MASK);
		if (cut >= 0 && cut < follow)
			follow = cut;
		send_byte(lead, eod && follow == 0);
		for (int i = 1; i <= follow; i++)
			send_byte(8'($urandom), eod && i == follow);
	endtask

	function automatic logic [BYTE_W-1:0] rand_lead();
		logic [BYTE_W-1:0] b;
		b = 8'($urandom);
		b[LEAD_MASK_BIT] = ($urandom_range(0, 9) >= 4);
		return b;
	endfunction

	// wait out every pending record, then the pipeline
	task automatic settle();
		data_valid <= 1'b0;
		while (records_left != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CNT_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		reg_writes++;
	endtask

	initial begin : stimulus
		logic [BYTE_W-1:0] opening [25];
		ending_t           ending;
		logic [CNT_W-1:0]  fc;
		logic [CNT_W-1:0]  pr;
		logic [CNT_W-1:0]  target;
		int                need;
		int                n;
		int                phase;
		int                start;
		opening = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h7F, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h9F, 8'h80, 8'h01, 8'h02, 8'h04, 8'h08,
			8'h80, 8'hE0,
			8'h81, 8'h55, 8'h90, 8'hAA, 8'h8A, 8'h10, 8'hFE};
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening[i])
			send_byte(opening[i], 1'b0);

		phase = 0;
		while (bytes_sent < RANDOM_BYTES + $size(opening)) begin
			settle();
			n = $urandom_range(15, 45);
			if (phase == 0) begin
				fc = 9'd1;
			end else if (phase == 1) begin
				fc = 9'd256;
			end else if (phase == 2) begin
				fc = KEPT_CHANNELS;
			end else begin
				case ($urandom_range(0, 5))
					0: fc = '0;
					1: fc = 9'd1;
					2: fc = 9'd256;
					3: fc = 9'($urandom_range(2, 40));
					4: fc = KEPT_CHANNELS;
					default: fc = 9'($urandom_range(257, 511));
				endcase
			end
			// keep the row limit ahead of anything this phase can reach
			need = int'(slot_row) + n + 2;
			if (need > 250) begin
				fc = 9'd256;
				need = int'(slot_row) + 3;
			end
			case ($urandom_range(0, 2))
				0: pr = MAX_ROWS;
				1: pr = 9'd511;
				default: pr = 9'($urandom_range(need, 511));
			endcase
			write_reg(REG_FILE_CHANNELS, fc);
			write_reg(REG_PATTERN_ROWS, pr);
			if (phase == 2)
				long_hold = 1'b1;
			jitter_on = (bytes_sent < RANDOM_BYTES * 4 / 5);
			start = bytes_sent;
			while (bytes_sent - start < n)
				send_slot(rand_lead(), 1'b0, -1);
			phase++;
		end

		// close the pattern on a chosen slot
		jitter_on = 1'b0;
		settle();
		ending = ending_t'($urandom_range(0, 5));
		if (ending == END_ROWS_KEPT || ending == END_EOD_KEPT)
			target = KEPT_CHANNELS - 1'b1;
		else if (ending == END_ROWS_DROPPED || ending == END_EOD_DROPPED)
			target = KEPT_CHANNELS + 1'b1;
		else
			target = $urandom_range(0, 1) ? KEPT_CHANNELS - 1'b1 : KEPT_CHANNELS + 1'b1;
		write_reg(REG_FILE_CHANNELS, target + 1'b1);
		write_reg(REG_PATTERN_ROWS, 9'd511);
		while (slot_channel != target)
			send_slot(rand_lead(), 1'b0, -1);
		settle();
		if (ending == END_ROWS_KEPT || ending == END_ROWS_DROPPED || ending == END_ROWS_WITH_EOD)
			write_reg(REG_PATTERN_ROWS, 9'($urandom_range(0, int'(slot_row) + 1)));
		if (ending == END_EOD_PARTIAL)
			send_slot({1'b0, 7'($urandom)}, 1'b1, $urandom_range(0, 3));
		else
			send_slot(rand_lead(), ending != END_ROWS_KEPT && ending != END_ROWS_DROPPED, -1);
		// after the end the block must stay silent
		repeat (8) send_byte(8'($urandom), 1'($urandom));
		settle();

		$display("sent %0d data bytes across %0d register writes, %0d records compared",
			bytes_sent, reg_writes, records_seen);
		$display("pattern closed by %s", ending.name());
		if (records_left != 0)
			$display("%0d expected records never arrived", records_left);
		if (mismatches == 0 && records_left == 0)
			$display("tracker_pattern_unpacker verification clean");
		else
			$display("tracker_pattern_unpacker verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/tpu_pkg.sv
rtl/core/tpu_slot_parser.sv
rtl/core/tpu_position.sv
rtl/core/tracker_pattern_unpacker.sv
dv/tracker_pattern_unpacker_check.sv
dv/tracker_pattern_unpacker_test.sv
